// ----- sv/bitlv_pkg.sv -----
// Shared types and constants for the BER integer TLV encoder.
package bitlv_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        OP_UNSIGNED = 2'd0,
        OP_SIGNED   = 2'd1,
        OP_BOOLEAN  = 2'd2,
        OP_HEADER   = 2'd3
    } t_op;

    typedef logic [7:0] t_byte;

    localparam int unsigned MAX_BYTES = 11;          // tag + length + 9 content bytes
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

    localparam t_byte LEN_LONG_FORM = 8'h80;         // long-form length marker
    localparam t_byte BOOL_TRUE     = 8'hFF;
    localparam t_byte BOOL_FALSE    = 8'h00;
    localparam t_byte ERR_BYTE      = 8'h00;

    // Result status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NO_ROOM = 1'b1;

endpackage

// ----- sv/bitlv_if.sv -----
// Request and result channel interfaces for the BER integer TLV encoder.
interface bitlv_req_if;
    logic                 valid;
    logic                 ready;
    bitlv_pkg::t_op       operation;
    logic [7:0]           tag;
    logic signed [63:0]   value;
    logic [31:0]          content_length;
    logic [15:0]          space_left;

    modport source (output valid, operation, tag, value, content_length, space_left,
                    input ready);
    modport sink   (input valid, operation, tag, value, content_length, space_left,
                    output ready);
endinterface

interface bitlv_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       status;

    modport source (output valid, out_byte, last, status, input ready);
    modport sink   (input valid, out_byte, last, status, output ready);
endinterface

// ----- sv/ber_integer_tlv_encoder.sv -----
// Top level of the BER integer TLV encoder: request register, encoder, byte frame.
//
// Each request is held in an input register, encoded in one pass into a frame
// register of up to eleven bytes (tag, length, content) and shifted out one byte
// per cycle while the result channel is ready, the final byte flagged by last. A
// request that does not fit space_left gives a single result with status set and
// byte 0. A request yields 1 to 11 results at the frame shifter; the next request
// is encoded while the current frame drains and its first byte follows the
// previous last byte with no gap. The input register keeps taking a new request
// whenever it is free or moving into the frame.
module ber_integer_tlv_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bitlv_req_if.sink          i_req,
    bitlv_res_if.source        o_res
);

    localparam int unsigned NB = bitlv_pkg::MAX_BYTES;
    localparam int unsigned CW = bitlv_pkg::CNT_W;

    // Request register
    logic               r_in_valid;
    bitlv_pkg::t_op     r_op;
    logic [7:0]         r_tag;
    logic [63:0]        r_value;
    logic [31:0]        r_clen;
    logic [15:0]        r_space;

    // Frame register
    bitlv_pkg::t_byte   r_bytes [NB];
    logic [CW-1:0]      r_cnt;
    logic               r_err;

    bitlv_pkg::t_byte   n_bytes [NB];
    logic [CW-1:0]      n_cnt;
    logic               n_err;

    logic               frame_load;
    logic               res_take;

    // Encoder intermediates
    logic               sign;
    logic [71:0]        ext;
    logic [3:0]         ncont;
    logic [71:0]        cont_sh;
    logic [2:0]         clen_nb;
    logic [31:0]        clen_sh;
    logic               clen_long;
    logic [3:0]         hdr_cnt;
    logic [32:0]        total;
    logic               fits;

    // Handshakes
    assign res_take   = o_res.valid && o_res.ready;
    assign frame_load = r_in_valid && ((r_cnt == '0) || ((r_cnt == CW'(1)) && res_take));
    assign i_req.ready = !r_in_valid || frame_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op    <= i_req.operation;
            r_tag   <= i_req.tag;
            r_value <= i_req.value;
            r_clen  <= i_req.content_length;
            r_space <= i_req.space_left;
        end
    end

    // Integer content: minimal byte count of the value extended to 72 bits
    always_comb begin
        sign  = (r_op == bitlv_pkg::OP_SIGNED) && r_value[63];
        ext   = {{8{sign}}, r_value};
        ncont = 4'd9;
        for (int k = 9; k >= 1; k--) begin
            if ((ext >> (8*k - 1)) == (sign ? ({72{1'b1}} >> (8*k - 1)) : 72'd0)) begin
                ncont = 4'(k);
            end
        end
        if (r_op == bitlv_pkg::OP_BOOLEAN) begin
            ncont = 4'd1;
        end
        // top-justify the content bytes
        cont_sh = ext << {(4'd9 - ncont), 3'b000};
        if (r_op == bitlv_pkg::OP_BOOLEAN) begin
            cont_sh = {((r_value != 64'd0) ? bitlv_pkg::BOOL_TRUE : bitlv_pkg::BOOL_FALSE),
                       64'd0};
        end
    end

    // Header-only length: short or long form
    always_comb begin
        clen_long = (r_clen[31:7] != 25'd0);
        if (r_clen[31:24] != 8'd0) begin
            clen_nb = 3'd4;
        end else if (r_clen[23:16] != 8'd0) begin
            clen_nb = 3'd3;
        end else if (r_clen[15:8] != 8'd0) begin
            clen_nb = 3'd2;
        end else begin
            clen_nb = 3'd1;
        end
        clen_sh = r_clen << {(3'd4 - clen_nb), 3'b000};
        hdr_cnt = clen_long ? (4'd2 + {1'b0, clen_nb}) : 4'd2;
    end

    // Space check: tag, length bytes and the content
    always_comb begin
        if (r_op == bitlv_pkg::OP_HEADER) begin
            total = 33'(hdr_cnt) + {1'b0, r_clen};
        end else begin
            total = 33'(4'd2 + ncont);
        end
        fits = ({17'd0, r_space} >= total);
    end

    // Build the next frame
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            n_bytes[i] = 8'h00;
        end
        n_err = bitlv_pkg::ST_OK;
        if (!fits) begin
            n_bytes[0] = bitlv_pkg::ERR_BYTE;
            n_cnt      = CW'(1);
            n_err      = bitlv_pkg::ST_NO_ROOM;
        end else if (r_op == bitlv_pkg::OP_HEADER) begin
            n_bytes[0] = r_tag;
            if (clen_long) begin
                n_bytes[1] = bitlv_pkg::LEN_LONG_FORM | {5'd0, clen_nb};
                for (int i = 0; i < 4; i++) begin
                    n_bytes[2 + i] = clen_sh[31 - 8*i -: 8];
                end
            end else begin
                n_bytes[1] = r_clen[7:0];
            end
            n_cnt = CW'(hdr_cnt);
        end else begin
            n_bytes[0] = r_tag;
            n_bytes[1] = {4'd0, ncont};
            for (int i = 0; i < 9; i++) begin
                n_bytes[2 + i] = cont_sh[71 - 8*i -: 8];
            end
            n_cnt = CW'(4'd2 + ncont);
        end
    end

    // Frame register: load a new frame or shift out one byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (frame_load) begin
            r_cnt <= n_cnt;
        end else if (res_take) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_load) begin
            r_bytes <= n_bytes;
            r_err   <= n_err;
        end else if (res_take) begin
            for (int i = 0; i < NB - 1; i++) begin
                r_bytes[i] <= r_bytes[i + 1];
            end
            r_bytes[NB - 1] <= 8'h00;
        end
    end

    assign o_res.valid    = (r_cnt != '0);
    assign o_res.out_byte = r_bytes[0];
    assign o_res.last     = (r_cnt == CW'(1));
    assign o_res.status   = r_err;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NB))
        else $error("frame count out of range");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && r_err |-> (r_cnt == CW'(1)) && (r_bytes[0] == bitlv_pkg::ERR_BYTE))
        else $error("error frame is not a single zero byte");

    a_ok_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_load && (n_err == bitlv_pkg::ST_OK) |=> (r_cnt >= CW'(2)))
        else $error("encoded frame shorter than tag and length");

    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !frame_load |=> r_in_valid && $stable(r_value) && $stable(r_op))
        else $error("pending request lost before entering the frame");

    a_load_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_load |-> (r_cnt == '0) || (o_res.last && res_take))
        else $error("frame overwritten before its last byte left");

endmodule

// ----- sim/tb_ber_integer_tlv_encoder.sv -----
// Self-checking testbench for the BER integer TLV encoder: directed and random requests.
module tb_ber_integer_tlv_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import bitlv_pkg::*;

    localparam int RANDOM_REQUESTS = 420;
    localparam int IDLE_LIMIT      = 2000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        t_op         op;
        t_byte       tag;
        logic [63:0] value;
        logic [31:0] clen;
        logic [15:0] space;
    } t_request;

    typedef struct packed {
        t_byte data;
        logic  last;
        logic  status;
    } t_tlv_byte;

    typedef logic [MAX_BYTES-1:0][7:0] t_frame;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bitlv_req_if req_if ();
    bitlv_res_if res_if ();

    ber_integer_tlv_encoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_request  pending_requests[$];
    t_tlv_byte expected_bytes[$];
    t_request  inflight;
    int        req_gap    = 0;
    int        req_calm   = 0;
    int        res_stall  = 0;
    int        res_calm   = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Encode one request into its TLV bytes; returns the byte count, total gives the space needed
    function automatic int build_frame(input t_request r, output t_frame frame,
                                       output logic [63:0] total);
        t_byte       body[9];
        t_byte       hdr[5];
        int          nbody;
        int          nhdr;
        int          sig;
        int          nlen;
        int          cnt;
        logic [31:0] hlen;
        logic [63:0] v;
        v     = r.value;
        nbody = 0;
        sig   = 0;
        cnt   = 0;
        frame = '0;
        case (r.op)
            OP_UNSIGNED, OP_SIGNED: begin
                if (r.op == OP_SIGNED && v[63]) begin
                    // shortest two's complement form of a negative value
                    sig = 1;
                    while (sig < 8 && ((~v) >> (sig * 8 - 1)) != 64'd0)
                        sig++;
                    for (int i = sig; i > 0; i--) begin
                        body[nbody] = v[(i - 1) * 8 +: 8];
                        nbody++;
                    end
                end else if (v == 64'd0) begin
                    body[0] = 8'h00;
                    nbody   = 1;
                end else begin
                    for (int i = 0; i < 8; i++)
                        if (v[i * 8 +: 8] != 8'h00)
                            sig = i + 1;
                    // leading zero keeps the top content bit clear
                    if (v[(sig - 1) * 8 + 7]) begin
                        body[nbody] = 8'h00;
                        nbody++;
                    end
                    for (int i = sig; i > 0; i--) begin
                        body[nbody] = v[(i - 1) * 8 +: 8];
                        nbody++;
                    end
                end
            end
            OP_BOOLEAN: begin
                body[0] = (v != 64'd0) ? BOOL_TRUE : BOOL_FALSE;
                nbody   = 1;
            end
            default: nbody = 0;
        endcase

        // definite length, short or long form
        hlen = (r.op == OP_HEADER) ? r.clen : 32'(nbody);
        if (hlen < 32'd128) begin
            hdr[0] = hlen[7:0];
            nhdr   = 1;
        end else begin
            if (hlen <= 32'hFF)          nlen = 1;
            else if (hlen <= 32'hFFFF)   nlen = 2;
            else if (hlen <= 32'hFFFFFF) nlen = 3;
            else                         nlen = 4;
            hdr[0] = LEN_LONG_FORM + 8'(nlen);
            for (int i = 0; i < nlen; i++)
                hdr[1 + i] = hlen[(nlen - 1 - i) * 8 +: 8];
            nhdr = nlen + 1;
        end
        total = 64'd1 + 64'(nhdr) + 64'(hlen);

        frame[cnt] = r.tag;
        cnt++;
        for (int i = 0; i < nhdr; i++) begin
            frame[cnt] = hdr[i];
            cnt++;
        end
        if (r.op != OP_HEADER)
            for (int i = 0; i < nbody; i++) begin
                frame[cnt] = body[i];
                cnt++;
            end
        return cnt;
    endfunction

    // Queue the bytes an accepted request must produce
    function automatic void predict_tlv(input t_request r);
        t_frame      frame;
        logic [63:0] total;
        int          cnt;
        cnt = build_frame(r, frame, total);
        if (64'(r.space) < total) begin
            expected_bytes.push_back('{data: ERR_BYTE, last: 1'b1, status: ST_NO_ROOM});
        end else begin
            for (int i = 0; i < cnt; i++)
                expected_bytes.push_back('{data: frame[i], last: (i == cnt - 1),
                                           status: ST_OK});
        end
    endfunction

    // Mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_delay(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 30) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 600) return 0;
        if (r < 880) return $urandom_range(1, 3);
        if (r < 975) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_request(input t_op op, input t_byte tag, input logic [63:0] value,
                                        input logic [31:0] clen, input logic [15:0] space);
        pending_requests.push_back('{op: op, tag: tag, value: value, clen: clen, space: space});
    endfunction

    // Random request, mostly sized to fit, some just short of room
    function automatic t_request random_request();
        t_request    r;
        t_frame      frame;
        logic [63:0] total;
        logic [63:0] raw;
        logic [63:0] mask;
        int          nb;
        int          mode;
        int          cnt;
        r.op  = t_op'(2'($urandom_range(0, 3)));
        r.tag = 8'($urandom);
        raw   = {$urandom, $urandom};
        nb    = $urandom_range(0, 8);
        mask  = (nb == 8) ? '1 : ((64'd1 << (nb * 8)) - 64'd1);
        if ($urandom_range(0, 1) == 1)
            r.value = raw | ~mask;   // sign-extended negative of nb bytes
        else
            r.value = raw & mask;
        mode = $urandom_range(0, 9);
        if (mode < 6)       r.clen = $urandom_range(0, 300);
        else if (mode < 8)  r.clen = $urandom_range(0, 65535);
        else if (mode == 8) r.clen = $urandom;
        else                r.clen = $urandom >> $urandom_range(0, 31);
        r.space = 16'hFFFF;
        cnt  = build_frame(r, frame, total);
        mode = $urandom_range(0, 9);
        if (mode < 4 && total <= 64'd65535)
            r.space = 16'(total + 64'($urandom_range(0, 3)) > 64'd65535 ?
                          total : total + 64'($urandom_range(0, 3)));
        else if (mode == 4 && total <= 64'd65536)
            r.space = 16'(total - 64'd1);
        else if (mode < 7)
            r.space = 16'hFFFF;
        else if (mode < 9)
            r.space = 16'($urandom);
        else
            r.space = 16'($urandom_range(0, 12));
        return r;
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready)
                predict_tlv(inflight);
            if (!req_if.valid || req_if.ready) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    inflight = pending_requests.pop_front();
                    req_if.operation      <= inflight.op;
                    req_if.tag            <= inflight.tag;
                    req_if.value          <= inflight.value;
                    req_if.content_length <= inflight.clen;
                    req_if.space_left     <= inflight.space;
                    req_if.valid          <= 1'b1;
                    req_gap = pick_delay(req_calm);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge i_clk) begin
        t_tlv_byte exp_byte;
        int        d;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result item: out_byte %h last %b status %b",
                           res_if.out_byte, res_if.last, res_if.status);
                    mismatches++;
                end else begin
                    exp_byte = expected_bytes.pop_front();
                    if (res_if.out_byte !== exp_byte.data) begin
                        $error("out_byte: expected %h, got %h", exp_byte.data, res_if.out_byte);
                        mismatches++;
                    end
                    if (res_if.last !== exp_byte.last) begin
                        $error("last: expected %b, got %b", exp_byte.last, res_if.last);
                        mismatches++;
                    end
                    if (res_if.status !== exp_byte.status) begin
                        $error("status: expected %b, got %b", exp_byte.status, res_if.status);
                        mismatches++;
                    end
                end
            end
            if (res_stall > 0) begin
                res_stall--;
                res_if.ready <= 1'b0;
            end else begin
                d = ($urandom_range(0, 3) == 0) ? pick_delay(res_calm) : 0;
                if (d > 0) begin
                    res_stall = d - 1;
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    // Count cycles in which no item moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        req_if.valid          = 1'b0;
        req_if.operation      = OP_UNSIGNED;
        req_if.tag            = 8'h00;
        req_if.value          = '0;
        req_if.content_length = '0;
        req_if.space_left     = '0;
        res_if.ready          = 1'b0;

        // unsigned: zero, top-bit boundaries, full width, exact fit and one short
        add_request(OP_UNSIGNED, 8'h00, 64'h0, 32'hFFFF_FFFF, 16'hFFFF);
        add_request(OP_UNSIGNED, 8'hFF, 64'h7F, 32'h0, 16'hFFFF);
        add_request(OP_UNSIGNED, 8'h02, 64'h80, 32'h1234_5678, 16'hFFFF);
        add_request(OP_UNSIGNED, 8'h02, 64'h100, 32'h0, 16'hFFFF);
        add_request(OP_UNSIGNED, 8'h5A, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 16'd11);
        add_request(OP_UNSIGNED, 8'hA5, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 16'd10);
        add_request(OP_UNSIGNED, 8'h02, 64'h1, 32'h0, 16'h0);
        // signed: negative boundaries, extremes, non-negative path
        add_request(OP_SIGNED, 8'h02, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 16'hFFFF);
        add_request(OP_SIGNED, 8'h02, 64'hFFFF_FFFF_FFFF_FF80, 32'h0, 16'hFFFF);
        add_request(OP_SIGNED, 8'h02, 64'hFFFF_FFFF_FFFF_FF7F, 32'h0, 16'hFFFF);
        add_request(OP_SIGNED, 8'h02, 64'h8000_0000_0000_0000, 32'h0, 16'd10);
        add_request(OP_SIGNED, 8'h02, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 16'hFFFF);
        add_request(OP_SIGNED, 8'h02, 64'h80, 32'h0, 16'd4);
        add_request(OP_SIGNED, 8'h02, 64'h0, 32'h0, 16'd3);
        // boolean false and true
        add_request(OP_BOOLEAN, 8'h01, 64'h0, 32'h0, 16'd3);
        add_request(OP_BOOLEAN, 8'h01, 64'h8000_0000_0000_0000, 32'h0, 16'hFFFF);
        add_request(OP_BOOLEAN, 8'h01, 64'h1, 32'h0, 16'd2);
        // header only: short form, one-, two- and four-byte long forms, room counted with content
        add_request(OP_HEADER, 8'h30, 64'h0, 32'd0, 16'hFFFF);
        add_request(OP_HEADER, 8'h30, 64'h0, 32'd127, 16'hFFFF);
        add_request(OP_HEADER, 8'h30, 64'h0, 32'd128, 16'hFFFF);
        add_request(OP_HEADER, 8'h04, 64'h0, 32'd255, 16'hFFFF);
        add_request(OP_HEADER, 8'h04, 64'h0, 32'd256, 16'd260);
        add_request(OP_HEADER, 8'h04, 64'h0, 32'd65531, 16'hFFFF);
        add_request(OP_HEADER, 8'h04, 64'h0, 32'd65532, 16'hFFFF);
        add_request(OP_HEADER, 8'h04, 64'h0, 32'h0100_0000, 16'hFFFF);
        add_request(OP_HEADER, 8'h04, 64'h0, 32'hFFFF_FFFF, 16'hFFFF);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
            pending_requests.push_back(random_request());

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to be taken and every byte to come back
        do
            @(negedge i_clk);
        while (pending_requests.size() != 0 || req_if.valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_bytes.size() != 0)
            $error("%0d expected result items never arrived", expected_bytes.size());
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
